// ----- hw/rtl/pbrle_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pbrle_pkg: shared definitions for the run-length compressor
// Default limits and the beat request/response structs between the
// byte sequencer and the output packer.
// ---------------------------------------------------------------------------
package pbrle_pkg;

	localparam int MAX_RUN_DEF     = 127;
	localparam int MAX_LITERAL_DEF = 127;

	localparam int WORD_BYTES = 8;
	localparam int CNT_W      = 4;
	localparam int TDATA_W    = 72;

	typedef struct packed {
		logic       vld;
		logic [7:0] data;
		logic       fin;
		logic       eos;
	} byte_req_t;

	typedef struct packed {
		logic byte_take;
		logic end_take;
	} byte_rsp_t;

endpackage

// ----- hw/rtl/pbrle_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pbrle_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module pbrle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 127,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/pbrle_packer.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pbrle_packer: code byte packer and output register
// Gathers code bytes into eight-byte words, low byte first, and holds
// one finished word on the master side.
// ---------------------------------------------------------------------------
module pbrle_packer
	import pbrle_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  byte_req_t            req,
	output byte_rsp_t            rsp,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// Fields from bit 0: out_bytes (64), byte_count (4), zero fill (4).
	output logic [TDATA_W-1:0]   m_axis_tdata,
	output logic                 m_axis_tlast,
	// Fields from bit 0: stream_done (1).
	output logic                 m_axis_tuser
);

	localparam logic [CNT_W-1:0] FULL = CNT_W'(WORD_BYTES);

	logic [8*WORD_BYTES-1:0] acc_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    out_valid_q;
	logic [8*WORD_BYTES-1:0] out_word_q;
	logic [CNT_W-1:0]        out_cnt_q;
	logic                    out_last_q;
	logic                    out_done_q;
	logic                    slot_free;
	logic                    push;

	always_comb begin
		slot_free     = !out_valid_q || m_axis_tready;
		rsp.byte_take = req.vld && ((cnt_q != FULL) || slot_free);
		rsp.end_take  = req.fin && ((cnt_q == '0) || slot_free);
		push          = slot_free && ((req.vld && (cnt_q == FULL)) ||
		                              (req.fin && (cnt_q != '0)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (rsp.byte_take) begin
				if ((cnt_q == '0) || (cnt_q == FULL)) begin
					cnt_q <= CNT_W'(1);
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end else if (rsp.end_take) begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_word_q <= acc_q;
			out_cnt_q  <= cnt_q;
			out_last_q <= req.fin;
			out_done_q <= req.fin && req.eos;
		end
		if (rsp.byte_take) begin
			if ((cnt_q == '0) || (cnt_q == FULL)) begin
				acc_q <= {{(8*WORD_BYTES-8){1'b0}}, req.data};
			end else begin
				acc_q[8*cnt_q[2:0] +: 8] <= req.data;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(TDATA_W-8*WORD_BYTES-CNT_W){1'b0}}, out_cnt_q, out_word_q};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_done_q;

endmodule

// ----- hw/rtl/packbits_style_rle_compressor.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// packbits_style_rle_compressor: signed-count run-length encoder
// A byte that starts or extends the pending run keeps the sequencer idle,
// unless it ends the stream. Any other byte closes the pending run, and the
// sequencer then issues its code bytes; an output stall holds the sequencer.
// A full code word is registered with the next code byte, the last one when
// the item ends, and is offered in the cycle after.
// Reset clears all control state; the literal RAM is not cleared.
// ---------------------------------------------------------------------------
module packbits_style_rle_compressor
	import pbrle_pkg::*;
#(
	parameter int MAX_RUN     = MAX_RUN_DEF,
	parameter int MAX_LITERAL = MAX_LITERAL_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	// Fields from bit 0: in_byte (8).
	input  logic [7:0]         s_axis_tdata,
	input  logic               s_axis_tlast,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// Fields from bit 0: out_bytes (64), byte_count (4), zero fill (4).
	output logic [TDATA_W-1:0] m_axis_tdata,
	output logic               m_axis_tlast,
	// Fields from bit 0: stream_done (1).
	output logic               m_axis_tuser
);

	localparam int RW = $clog2(MAX_RUN + 1);
	localparam int LW = $clog2(MAX_LITERAL + 1);
	localparam int AW = $clog2(MAX_LITERAL);

	typedef enum logic [7:0] {
		ST_IDLE      = 8'b0000_0001,
		ST_CLOSE     = 8'b0000_0010,
		ST_AFTER     = 8'b0000_0100,
		ST_RUN_CNT   = 8'b0000_1000,
		ST_RUN_VAL   = 8'b0001_0000,
		ST_FLUSH_HDR = 8'b0010_0000,
		ST_FLUSH_DAT = 8'b0100_0000,
		ST_DONE      = 8'b1000_0000
	} state_t;

	typedef enum logic [1:0] {
		RET_RUN   = 2'd0,
		RET_AFTER = 2'd1,
		RET_DONE  = 2'd2
	} ret_t;

	state_t          state_q;
	ret_t            ret_q;
	logic            phase_q;
	logic [7:0]      b_q;
	logic            eos_q;
	logic            run_active_q;
	logic [7:0]      run_value_q;
	logic [RW-1:0]   run_length_q;
	logic [LW-1:0]   lit_len_q;
	logic [AW-1:0]   idx_q;

	logic            cont;
	logic            last_lit;
	logic            ram_we;
	logic [AW-1:0]   ram_raddr;
	logic [7:0]      ram_rdata;
	byte_req_t       req;
	byte_rsp_t       rsp;

	assign s_axis_tready = (state_q == ST_IDLE);

	always_comb begin
		cont     = run_active_q && (s_axis_tdata == run_value_q) &&
		           (run_length_q < RW'(MAX_RUN));
		last_lit = (idx_q == AW'(lit_len_q - 1'b1));
		ram_we   = (state_q == ST_CLOSE) && (run_length_q == RW'(1));
		if (state_q == ST_FLUSH_DAT) begin
			ram_raddr = (rsp.byte_take && !last_lit) ? AW'(idx_q + 1'b1) : idx_q;
		end else begin
			ram_raddr = '0;
		end
		req.fin = (state_q == ST_DONE);
		req.eos = eos_q;
		unique case (state_q)
			ST_RUN_CNT: begin
				req.vld  = 1'b1;
				req.data = 8'(run_length_q);
			end
			ST_RUN_VAL: begin
				req.vld  = 1'b1;
				req.data = run_value_q;
			end
			ST_FLUSH_HDR: begin
				req.vld  = 1'b1;
				req.data = (lit_len_q == LW'(1)) ? 8'd1 : 8'(9'd256 - 9'(lit_len_q));
			end
			ST_FLUSH_DAT: begin
				req.vld  = 1'b1;
				req.data = ram_rdata;
			end
			default: begin
				req.vld  = 1'b0;
				req.data = 8'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ret_q        <= RET_DONE;
			phase_q      <= 1'b0;
			b_q          <= 8'd0;
			eos_q        <= 1'b0;
			run_active_q <= 1'b0;
			run_value_q  <= 8'd0;
			run_length_q <= '0;
			lit_len_q    <= '0;
			idx_q        <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						b_q   <= s_axis_tdata;
						eos_q <= s_axis_tlast;
						if (cont) begin
							run_length_q <= run_length_q + 1'b1;
							phase_q      <= 1'b1;
							state_q      <= s_axis_tlast ? ST_CLOSE : ST_IDLE;
						end else if (run_active_q) begin
							phase_q <= 1'b0;
							state_q <= ST_CLOSE;
						end else begin
							run_active_q <= 1'b1;
							run_value_q  <= s_axis_tdata;
							run_length_q <= RW'(1);
							phase_q      <= 1'b1;
							state_q      <= s_axis_tlast ? ST_CLOSE : ST_IDLE;
						end
					end
				end
				ST_CLOSE: begin
					if (run_length_q == RW'(1)) begin
						lit_len_q <= lit_len_q + 1'b1;
						if (lit_len_q == LW'(MAX_LITERAL - 1)) begin
							ret_q   <= RET_AFTER;
							state_q <= ST_FLUSH_HDR;
						end else begin
							state_q <= ST_AFTER;
						end
					end else if (lit_len_q != '0) begin
						ret_q   <= RET_RUN;
						state_q <= ST_FLUSH_HDR;
					end else begin
						state_q <= ST_RUN_CNT;
					end
				end
				ST_RUN_CNT: begin
					if (rsp.byte_take) begin
						state_q <= ST_RUN_VAL;
					end
				end
				ST_RUN_VAL: begin
					if (rsp.byte_take) begin
						state_q <= ST_AFTER;
					end
				end
				ST_AFTER: begin
					if (!phase_q) begin
						run_active_q <= 1'b1;
						run_value_q  <= b_q;
						run_length_q <= RW'(1);
						if (eos_q) begin
							phase_q <= 1'b1;
							state_q <= ST_CLOSE;
						end else begin
							state_q <= ST_DONE;
						end
					end else begin
						run_active_q <= 1'b0;
						run_value_q  <= 8'd0;
						run_length_q <= '0;
						if (lit_len_q != '0) begin
							ret_q   <= RET_DONE;
							state_q <= ST_FLUSH_HDR;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_FLUSH_HDR: begin
					if (rsp.byte_take) begin
						idx_q   <= '0;
						state_q <= ST_FLUSH_DAT;
					end
				end
				ST_FLUSH_DAT: begin
					if (rsp.byte_take) begin
						if (last_lit) begin
							lit_len_q <= '0;
							unique case (ret_q)
								RET_RUN:   state_q <= ST_RUN_CNT;
								RET_AFTER: state_q <= ST_AFTER;
								default:   state_q <= ST_DONE;
							endcase
						end else begin
							idx_q <= AW'(idx_q + 1'b1);
						end
					end
				end
				ST_DONE: begin
					if (rsp.end_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	pbrle_ram #(
		.WIDTH(8),
		.DEPTH(MAX_LITERAL)
	) u_lit_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(lit_len_q)),
		.wdata(run_value_q),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	pbrle_packer u_packer (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.rsp          (rsp),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

endmodule

// ----- dv/packbits_style_rle_compressor_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// packbits_style_rle_compressor_test: self-checking bench for the compressor
// Byte streams go in on the slave stream port with random gaps. Each beat
// that the block takes is run through an encoder model here, and the code
// words it predicts are compared with those leaving the master port, which
// stalls at random. Streams cover runs, lone bytes, full literal groups,
// runs at their length limit and the widest burst of code words.
// ---------------------------------------------------------------------------
module packbits_style_rle_compressor_test;
	import pbrle_pkg::*;

	typedef struct {
		logic [7:0] value;
		logic       eos;
		bit         drain;
	} raw_byte_t;

	typedef struct {
		logic [WORD_BYTES*8-1:0] bytes;
		logic [CNT_W-1:0]        cnt;
		logic                    burst_end;
		logic                    stream_end;
	} code_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [7:0]         s_axis_tdata = '0;
	logic               s_axis_tlast = 1'b0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [TDATA_W-1:0] m_axis_tdata;
	logic               m_axis_tlast;
	logic               m_axis_tuser;

	raw_byte_t  pending_bytes[$];
	code_word_t expected_words[$];
	logic [7:0] code_bytes[$];

	bit          run_on = 1'b0;
	logic [7:0]  run_val = '0;
	int unsigned run_len = 0;
	logic [7:0]  lone_store[MAX_LITERAL_DEF];
	int unsigned lone_cnt = 0;

	int         flaw_count = 0;
	int         gap_left = 0;
	int         stall_left = 0;
	int         stall_draw;
	bit         sender_quiet = 1'b0;
	bit         receiver_quiet = 1'b0;
	raw_byte_t  next_byte;
	code_word_t want;
	logic [7:0] last_pushed = '0;
	int         stream_idx;

	packbits_style_rle_compressor dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_flaw(string msg);
		if (flaw_count < 40) begin
			$display("ERROR at %0t: %s", $time, msg);
		end
		flaw_count++;
	endtask

	function automatic void flush_lone();
		if (lone_cnt == 0) begin
			return;
		end
		code_bytes.push_back(lone_cnt == 1 ? 8'd1 : 8'(256 - lone_cnt));
		for (int i = 0; i < lone_cnt; i++) begin
			code_bytes.push_back(lone_store[i]);
		end
		lone_cnt = 0;
	endfunction

	function automatic void add_lone(logic [7:0] v);
		if (lone_cnt < MAX_LITERAL_DEF) begin
			lone_store[lone_cnt] = v;
			lone_cnt++;
		end
		if (lone_cnt >= MAX_LITERAL_DEF) begin
			flush_lone();
		end
	endfunction

	function automatic void close_run();
		if (!run_on) begin
			return;
		end
		if (run_len <= 1) begin
			add_lone(run_val);
		end else begin
			flush_lone();
			code_bytes.push_back(8'(run_len));
			code_bytes.push_back(run_val);
		end
		run_on = 1'b0;
		run_len = 0;
	endfunction

	// Runs one raw byte through the encoder and queues the code words it yields.
	function automatic void encode_byte(logic [7:0] b, logic eos);
		code_word_t w;
		int         n_words;
		code_bytes.delete();
		if (run_on && b == run_val && run_len < MAX_RUN_DEF) begin
			run_len++;
		end else begin
			close_run();
			run_on = 1'b1;
			run_val = b;
			run_len = 1;
		end
		if (eos) begin
			close_run();
			flush_lone();
			run_val = '0;
		end
		n_words = (code_bytes.size() + WORD_BYTES - 1) / WORD_BYTES;
		for (int k = 0; k < n_words; k++) begin
			w.bytes = '0;
			w.cnt = '0;
			for (int j = 0; j < WORD_BYTES; j++) begin
				if (k * WORD_BYTES + j < code_bytes.size()) begin
					w.bytes[8*j +: 8] = code_bytes[k * WORD_BYTES + j];
					w.cnt = w.cnt + 1'b1;
				end
			end
			w.burst_end = (k == n_words - 1);
			w.stream_end = w.burst_end && eos;
			expected_words.push_back(w);
		end
	endfunction

	task automatic push_byte(logic [7:0] v, bit drain = 1'b0);
		raw_byte_t r;
		r.value = v;
		r.eos = 1'b0;
		r.drain = drain;
		pending_bytes.push_back(r);
		last_pushed = v;
	endtask

	task automatic end_stream();
		pending_bytes[pending_bytes.size() - 1].eos = 1'b1;
	endtask

	task automatic add_run(logic [7:0] v, int len);
		for (int i = 0; i < len; i++) begin
			push_byte(v);
		end
	endtask

	// Each byte differs from the one before it, so all of them stand alone.
	task automatic add_lones(int len);
		for (int i = 0; i < len; i++) begin
			push_byte(8'(last_pushed + $urandom_range(1, 255)));
		end
	endtask

	task automatic add_random_stream(bit drain);
		int segs;
		int len;
		push_byte(8'($urandom_range(0, 255)), drain);
		segs = $urandom_range(1, 6);
		for (int s = 0; s < segs; s++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 60) :
						$urandom_range(2, 8);
					add_run(($urandom_range(0, 3) == 0) ? last_pushed :
						8'($urandom_range(0, 255)), len);
				end
				5, 6, 7: begin
					add_lones($urandom_range(1, 12));
				end
				default: begin
					len = $urandom_range(1, 6);
					for (int i = 0; i < len; i++) begin
						push_byte(8'($urandom_range(0, 3)));
					end
				end
			endcase
		end
		end_stream();
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			gap_left <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (gap_left != 0) begin
				s_axis_tvalid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_bytes.size() != 0 && !(pending_bytes[0].drain &&
			    (s_axis_tvalid || expected_words.size() != 0))) begin
				next_byte = pending_bytes.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= next_byte.value;
				s_axis_tlast <= next_byte.eos;
				if ($urandom_range(0, 31) == 0) begin
					sender_quiet = !sender_quiet;
				end
				gap_left <= sender_quiet ? 0 : $urandom_range(0, 4);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			if ($urandom_range(0, 31) == 0) begin
				receiver_quiet = !receiver_quiet;
			end
			stall_draw = receiver_quiet ? 0 : $urandom_range(0, 4);
			m_axis_tready <= (stall_draw == 0);
			stall_left <= (stall_draw == 0) ? 0 : stall_draw - 1;
		end else if (stall_left != 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			run_on = 1'b0;
			run_val = '0;
			run_len = 0;
			lone_cnt = 0;
			expected_words.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				encode_byte(s_axis_tdata, s_axis_tlast);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_words.size() == 0) begin
					report_flaw($sformatf("code word %h arrived with none expected",
						m_axis_tdata));
				end else begin
					want = expected_words.pop_front();
					if (m_axis_tdata[WORD_BYTES*8-1:0] !== want.bytes) begin
						report_flaw($sformatf("out_bytes %h, expected %h",
							m_axis_tdata[WORD_BYTES*8-1:0], want.bytes));
					end
					if (m_axis_tdata[WORD_BYTES*8 +: CNT_W] !== want.cnt) begin
						report_flaw($sformatf("byte_count %0d, expected %0d",
							m_axis_tdata[WORD_BYTES*8 +: CNT_W], want.cnt));
					end
					if (m_axis_tlast !== want.burst_end) begin
						report_flaw($sformatf("last_of_burst %b, expected %b",
							m_axis_tlast, want.burst_end));
					end
					if (m_axis_tuser !== want.stream_end) begin
						report_flaw($sformatf("stream_done %b, expected %b",
							m_axis_tuser, want.stream_end));
					end
				end
			end
		end
	end

	initial begin
		// Short streams: lone extreme bytes, a run of the top value,
		// runs around a single lone byte, and one group of eight lone bytes.
		push_byte(8'h00);
		end_stream();
		push_byte(8'hFF);
		end_stream();
		add_run(8'hFF, 3);
		end_stream();
		add_run(8'h00, 2);
		push_byte(8'h80);
		add_run(8'h7F, 2);
		end_stream();
		for (int i = 0; i < 8; i++) begin
			push_byte(8'(1 << i), i == 0);
		end
		end_stream();

		stream_idx = 0;
		while (pending_bytes.size() < 420) begin
			case (stream_idx)
				0: begin
					// The literal group fills up and leaves at once.
					push_byte(8'($urandom_range(0, 255)), 1'b1);
					add_lones(MAX_LITERAL_DEF + 2);
					end_stream();
				end
				1: begin
					// One byte short of a full group, then a run that overflows
					// its limit: the widest burst of code words.
					push_byte(8'($urandom_range(0, 255)), 1'b1);
					add_lones(MAX_LITERAL_DEF - 2);
					add_run(8'(last_pushed + 1), MAX_RUN_DEF + 2);
					end_stream();
				end
				default: begin
					add_random_stream(stream_idx % 7 == 0);
				end
			endcase
			stream_idx++;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() != 0 || s_axis_tvalid) begin
			@(posedge clk);
		end
		while (expected_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (200) @(posedge clk);
		if (flaw_count == 0) begin
			$display("packbits_style_rle_compressor: match");
		end else begin
			$display("packbits_style_rle_compressor: mismatch");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("packbits_style_rle_compressor: mismatch");
		$finish;
	end

endmodule

// ----- packbits_style_rle_compressor.f -----
hw/rtl/pbrle_pkg.sv
hw/rtl/pbrle_ram.sv
hw/rtl/pbrle_packer.sv
hw/rtl/packbits_style_rle_compressor.sv
dv/packbits_style_rle_compressor_test.sv
